### rtl/stt_pkg.sv
package stt_pkg;

   // width of the running word and string length counter
   localparam int LENGTH_BITS = 16;

   localparam int KIND_BITS  = 4;
   localparam int VALUE_BITS = 31;
   localparam int LEN_OUT_BITS = 16;
   localparam int MAX_RESULTS = 3;

   localparam logic [VALUE_BITS-1:0] VALUE_MAX = 31'h7FFF_FFFF;

   // token kinds
   localparam logic [KIND_BITS-1:0] KIND_TEXT    = 4'd0;
   localparam logic [KIND_BITS-1:0] KIND_IDENT   = 4'd1;
   localparam logic [KIND_BITS-1:0] KIND_STRING  = 4'd2;
   localparam logic [KIND_BITS-1:0] KIND_INTEGER = 4'd3;
   localparam logic [KIND_BITS-1:0] KIND_IF      = 4'd4;
   localparam logic [KIND_BITS-1:0] KIND_WHILE   = 4'd5;
   localparam logic [KIND_BITS-1:0] KIND_ASSIGN  = 4'd6;
   localparam logic [KIND_BITS-1:0] KIND_EQUALS  = 4'd7;
   localparam logic [KIND_BITS-1:0] KIND_LPAREN  = 4'd8;
   localparam logic [KIND_BITS-1:0] KIND_RPAREN  = 4'd9;
   localparam logic [KIND_BITS-1:0] KIND_LCURLY  = 4'd10;
   localparam logic [KIND_BITS-1:0] KIND_RCURLY  = 4'd11;
   localparam logic [KIND_BITS-1:0] KIND_PLUS    = 4'd12;
   localparam logic [KIND_BITS-1:0] KIND_MINUS   = 4'd13;
   localparam logic [KIND_BITS-1:0] KIND_END     = 4'd14;
   localparam logic [KIND_BITS-1:0] KIND_UNTERM  = 4'd15;

   // character codes
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_EQUAL  = 8'h3D;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_LCURLY = 8'h7B;
   localparam logic [7:0] CH_RCURLY = 8'h7D;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;

   typedef struct packed {
      logic [KIND_BITS-1:0]    kind;
      logic [7:0]              text_char;
      logic [VALUE_BITS-1:0]   int_value;
      logic                    value_overflow;
      logic [LEN_OUT_BITS-1:0] token_length;
   } rec_type;

   // all results caused by one input word
   typedef struct packed {
      logic [1:0]                   count;
      rec_type [MAX_RESULTS-1:0]    recs;
   } bundle_type;

   typedef struct packed {
      logic                   in_string;
      logic                   pending_equal_sign;
      logic [LENGTH_BITS-1:0] word_length;
      logic                   all_digits;
      logic                   matches_if;
      logic                   matches_while;
      logic [VALUE_BITS-1:0]  value_accumulator;
      logic                   overflow_seen;
   } state_type;

   localparam state_type STATE_RESET = '{
      in_string: 1'b0, pending_equal_sign: 1'b0, word_length: '0,
      all_digits: 1'b1, matches_if: 1'b1, matches_while: 1'b1,
      value_accumulator: '0, overflow_seen: 1'b0};

   // low 16 bits of the length counter, zero-extended when narrower
   function automatic logic [LEN_OUT_BITS-1:0] len_out(input logic [LENGTH_BITS-1:0] l);
      logic [LENGTH_BITS+LEN_OUT_BITS-1:0] wide;
      wide = {{LEN_OUT_BITS{1'b0}}, l};
      return wide[LEN_OUT_BITS-1:0];
   endfunction

   function automatic rec_type make_rec(input logic [KIND_BITS-1:0] kind,
                                        input logic [7:0] ch,
                                        input logic [VALUE_BITS-1:0] val,
                                        input logic ovf,
                                        input logic [LEN_OUT_BITS-1:0] len);
      rec_type r;
      r.kind = kind;
      r.text_char = ch;
      r.int_value = val;
      r.value_overflow = ovf;
      r.token_length = len;
      return r;
   endfunction

   function automatic logic [7:0] kw_if_char(input logic pos);
      return pos ? 8'h66 : 8'h69;
   endfunction

   function automatic logic [7:0] kw_while_char(input logic [2:0] pos);
      logic [7:0] c;
      unique case (pos)
         3'd0: c = 8'h77;
         3'd1: c = 8'h68;
         3'd2: c = 8'h69;
         3'd3: c = 8'h6C;
         3'd4: c = 8'h65;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

### rtl/stt_step.sv
module stt_step
   import stt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       take,
   input  logic [7:0] byte_in,
   input  logic       end_in,
   output bundle_type bundle
);

   state_type st_ff;
   state_type st_in;

   // tokenizer state, advanced once per taken word
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= STATE_RESET;
      end else if (take) begin
         st_ff <= st_in;
      end
   end

   // per-byte decisions and result records
   always_comb begin
      logic [1:0]             n;
      rec_type                close_rec;
      logic                   close_valid;
      logic                   is_sym;
      logic [KIND_BITS-1:0]   sym_kind;
      logic                   is_ws;
      logic                   is_digit;
      logic [3:0]             digit;
      logic [VALUE_BITS+4:0]  wide;
      logic                   do_plain;
      logic [LENGTH_BITS-1:0] len_grow;
      n = 2'd0;
      bundle.recs = '0;
      st_in = st_ff;
      do_plain = 1'b0;

      // saturating length increment
      len_grow = (&st_ff.word_length) ? st_ff.word_length
                                      : st_ff.word_length + 1'b1;

      // closing result for the running word
      close_valid = st_ff.word_length != '0;
      if (st_ff.matches_if && st_ff.word_length == LENGTH_BITS'(2)) begin
         close_rec = make_rec(KIND_IF, 8'd0, '0, 1'b0, len_out(st_ff.word_length));
      end else if (st_ff.matches_while && st_ff.word_length == LENGTH_BITS'(5)) begin
         close_rec = make_rec(KIND_WHILE, 8'd0, '0, 1'b0, len_out(st_ff.word_length));
      end else if (st_ff.all_digits) begin
         close_rec = make_rec(KIND_INTEGER, 8'd0, st_ff.value_accumulator,
                              st_ff.overflow_seen, len_out(st_ff.word_length));
      end else begin
         close_rec = make_rec(KIND_IDENT, 8'd0, '0, 1'b0, len_out(st_ff.word_length));
      end

      // byte classes
      is_sym = 1'b1;
      unique case (byte_in)
         CH_LPAREN: sym_kind = KIND_LPAREN;
         CH_RPAREN: sym_kind = KIND_RPAREN;
         CH_LCURLY: sym_kind = KIND_LCURLY;
         CH_RCURLY: sym_kind = KIND_RCURLY;
         CH_PLUS:   sym_kind = KIND_PLUS;
         CH_MINUS:  sym_kind = KIND_MINUS;
         default: begin
            sym_kind = KIND_TEXT;
            is_sym = 1'b0;
         end
      endcase
      is_ws = (byte_in == CH_SPACE) || (byte_in == CH_TAB) || (byte_in == CH_NL);
      is_digit = (byte_in >= CH_ZERO) && (byte_in <= CH_NINE);
      digit = 4'(byte_in - CH_ZERO);

      // times-ten plus digit
      wide = ({5'd0, st_ff.value_accumulator} << 3)
           + ({5'd0, st_ff.value_accumulator} << 1)
           + {{(VALUE_BITS+1){1'b0}}, digit};

      if (end_in) begin
         // flush and end of text
         if (st_ff.pending_equal_sign) begin
            bundle.recs[n] = make_rec(KIND_ASSIGN, 8'd0, '0, 1'b0, '0);
            n = n + 2'd1;
         end
         if (st_ff.in_string) begin
            bundle.recs[n] = make_rec(KIND_UNTERM, 8'd0, '0, 1'b0,
                                      len_out(st_ff.word_length));
            n = n + 2'd1;
         end else if (close_valid) begin
            bundle.recs[n] = close_rec;
            n = n + 2'd1;
         end
         bundle.recs[n] = make_rec(KIND_END, 8'd0, '0, 1'b0, '0);
         n = n + 2'd1;
         st_in = STATE_RESET;
      end else if (st_ff.in_string) begin
         // inside a string every byte is echoed until the closing quote
         if (byte_in == CH_QUOTE) begin
            bundle.recs[n] = make_rec(KIND_STRING, 8'd0, '0, 1'b0,
                                      len_out(st_ff.word_length));
            n = n + 2'd1;
            st_in = STATE_RESET;
         end else begin
            st_in.word_length = len_grow;
            bundle.recs[n] = make_rec(KIND_TEXT, byte_in, '0, 1'b0, '0);
            n = n + 2'd1;
         end
      end else if (st_ff.pending_equal_sign) begin
         // second byte decides between equals and assignment
         st_in.pending_equal_sign = 1'b0;
         if (byte_in == CH_EQUAL) begin
            bundle.recs[n] = make_rec(KIND_EQUALS, 8'd0, '0, 1'b0, '0);
            n = n + 2'd1;
         end else begin
            bundle.recs[n] = make_rec(KIND_ASSIGN, 8'd0, '0, 1'b0, '0);
            n = n + 2'd1;
            do_plain = 1'b1;
         end
      end else begin
         do_plain = 1'b1;
      end

      // ordinary byte outside a string
      if (do_plain) begin
         if (byte_in == CH_QUOTE || byte_in == CH_EQUAL || is_sym || is_ws) begin
            if (close_valid) begin
               bundle.recs[n] = close_rec;
               n = n + 2'd1;
            end
            st_in.word_length = '0;
            st_in.all_digits = 1'b1;
            st_in.matches_if = 1'b1;
            st_in.matches_while = 1'b1;
            st_in.value_accumulator = '0;
            st_in.overflow_seen = 1'b0;
            if (byte_in == CH_QUOTE) begin
               st_in.in_string = 1'b1;
            end
            if (byte_in == CH_EQUAL) begin
               st_in.pending_equal_sign = 1'b1;
            end
            if (is_sym) begin
               bundle.recs[n] = make_rec(sym_kind, 8'd0, '0, 1'b0, '0);
               n = n + 2'd1;
            end
         end else begin
            if (!(st_ff.word_length < LENGTH_BITS'(2)
                  && kw_if_char(st_ff.word_length[0]) == byte_in)) begin
               st_in.matches_if = 1'b0;
            end
            if (!(st_ff.word_length < LENGTH_BITS'(5)
                  && kw_while_char(st_ff.word_length[2:0]) == byte_in)) begin
               st_in.matches_while = 1'b0;
            end
            if (is_digit) begin
               if (st_ff.all_digits) begin
                  if (wide > {5'd0, VALUE_MAX}) begin
                     st_in.value_accumulator = VALUE_MAX;
                     st_in.overflow_seen = 1'b1;
                  end else begin
                     st_in.value_accumulator = wide[VALUE_BITS-1:0];
                  end
               end
            end else begin
               st_in.all_digits = 1'b0;
            end
            st_in.word_length = len_grow;
            bundle.recs[n] = make_rec(KIND_TEXT, byte_in, '0, 1'b0, '0);
            n = n + 2'd1;
         end
      end

      bundle.count = n;
   end

endmodule

### rtl/stt_bundle.sv
module stt_bundle
   import stt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  bundle_type bundle,
   output logic       room,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output rec_type    rsp_rec,
   output logic       rsp_last
);

   logic [1:0]                cnt_ff;
   logic [1:0]                cnt_in;
   logic [1:0]                idx_ff;
   logic [1:0]                idx_in;
   rec_type [MAX_RESULTS-1:0] recs_ff;

   // current result and whether it closes the bundle
   assign rsp_tvalid = cnt_ff != 2'd0;
   assign rsp_rec    = recs_ff[idx_ff];
   assign rsp_last   = idx_ff == (cnt_ff - 2'd1);

   // a new bundle may enter once the last result leaves
   assign room = !rsp_tvalid || (rsp_tready && rsp_last);

   always_comb begin
      cnt_in = cnt_ff;
      idx_in = idx_ff;
      if (load) begin
         cnt_in = bundle.count;
         idx_in = 2'd0;
      end else if (rsp_tvalid && rsp_tready) begin
         if (rsp_last) begin
            cnt_in = 2'd0;
            idx_in = 2'd0;
         end else begin
            idx_in = idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
         idx_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
         idx_ff <= idx_in;
      end
   end

   // result payload, no reset
   always_ff @(posedge clock) begin
      if (load) begin
         recs_ff <= bundle.recs;
      end
   end

endmodule

### rtl/source_text_tokenizer.sv
// Byte-serial tokenizer. Each input word carries one source byte, or with
// req_tlast high the end of text (the byte is then ignored). A byte is taken
// into an input register, tokenized combinationally, and its zero to two
// results are loaded together into a result register that feeds the rsp
// channel one word per cycle while rsp_tready is high; rsp_tlast marks the
// last result of a byte. Throughput is one byte per cycle while rsp_tready
// is high and each byte gives at most one result; a byte with several holds
// the single result port until its last one is taken. A byte goes through the
// input and result registers; one can wait in the first while results stall.
module source_text_tokenizer
   import stt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] source_byte
   input  logic        req_tlast,   // end_of_input
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // [7:0] text_char, [38:8] int_value,
                                    // [39] value_overflow, [55:40] token_length
   output logic [3:0]  rsp_tuser,   // [3:0] token_kind
   output logic        rsp_tlast    // last_of_run
);

   logic       in_valid_ff;
   logic [7:0] byte_ff;
   logic       end_ff;
   logic       room;
   logic       take;
   bundle_type bundle;
   rec_type    rsp_rec;

   // input register
   assign take       = in_valid_ff && room;
   assign req_tready = !in_valid_ff || room;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tvalid && req_tready) begin
         in_valid_ff <= 1'b1;
      end else if (take) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         byte_ff <= req_tdata;
         end_ff  <= req_tlast;
      end
   end

   // tokenizer state and per-byte results
   stt_step u_step (
      .clock   (clock),
      .reset   (reset),
      .take    (take),
      .byte_in (byte_ff),
      .end_in  (end_ff),
      .bundle  (bundle)
   );

   // result register and serializer
   stt_bundle u_bundle (
      .clock      (clock),
      .reset      (reset),
      .load       (take),
      .bundle     (bundle),
      .room       (room),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_rec    (rsp_rec),
      .rsp_last   (rsp_tlast)
   );

   // pack the result word
   assign rsp_tdata = {rsp_rec.token_length, rsp_rec.value_overflow,
                       rsp_rec.int_value, rsp_rec.text_char};
   assign rsp_tuser = rsp_rec.kind;

endmodule

### rtl/stt_checker.sv
module stt_checker
   import stt_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [55:0] rsp_tdata,
   input logic [3:0]  rsp_tuser,
   input logic        rsp_tlast
);

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp word dropped while stalled");

   // a stalled result keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("rsp payload changed while stalled");

   // end of text is always the final result of its byte
   a_end_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_END |-> rsp_tlast)
      else $error("end token not marked last");

   // only text results carry a character
   a_char_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != KIND_TEXT |-> rsp_tdata[7:0] == 8'd0)
      else $error("character on a non-text result");

   // only integer results carry a value or overflow flag
   a_value_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != KIND_INTEGER |-> rsp_tdata[39:8] == 32'd0)
      else $error("value on a non-integer result");

endmodule

bind source_text_tokenizer stt_checker u_stt_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

### dv/tb_source_text_tokenizer.sv
`timescale 1ns / 100ps

module tb_source_text_tokenizer;
   import stt_pkg::*;

   localparam int NDIRECTED      = 31;
   localparam int RANDOM_WORDS   = 350;
   localparam int CALM_AFTER     = 300;
   localparam int LONG_RUN       = 12;
   localparam int WATCHDOG_LIMIT = 2000;

   // keyword spellings, first character in the top byte
   localparam logic [15:0] KW_IF    = "if";
   localparam logic [39:0] KW_WHILE = "while";

   // one token as seen on the rsp channel
   typedef struct packed {
      logic [3:0]  kind;
      logic [7:0]  ch;
      logic [30:0] val;
      logic        ovf;
      logic [15:0] len;
      logic        last;
   } token_type;

   // directed row: input word plus an optional typed-in single result
   typedef struct packed {
      logic        eoi;
      logic [7:0]  b;
      logic        typed;
      logic [3:0]  kind;
      logic [7:0]  ch;
      logic [15:0] len;
   } stim_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;
   logic [3:0]  rsp_tuser;
   logic        rsp_tlast;

   state_type   lex = STATE_RESET;
   token_type   step_tokens[$];
   token_type   pending_tokens[$];
   bit          calm = 1'b0;
   int          words_sent = 0;
   int          mismatches = 0;
   int          quiet_cycles = 0;
   int          stall_left = 0;

   stim_type directed_rows [NDIRECTED] = '{
      '{1'b0, 8'h00,     1'b1, KIND_TEXT,   8'h00, 16'd0},
      '{1'b0, 8'hFF,     1'b1, KIND_TEXT,   8'hFF, 16'd0},
      '{1'b0, CH_SPACE,  1'b0, KIND_TEXT,   8'h00, 16'd0},
      '{1'b0, CH_LPAREN, 1'b1, KIND_LPAREN, 8'h00, 16'd0},
      '{1'b0, CH_RPAREN, 1'b1, KIND_RPAREN, 8'h00, 16'd0},
      '{1'b0, CH_LCURLY, 1'b1, KIND_LCURLY, 8'h00, 16'd0},
      '{1'b0, CH_RCURLY, 1'b1, KIND_RCURLY, 8'h00, 16'd0},
      '{1'b0, CH_PLUS,   1'b1, KIND_PLUS,   8'h00, 16'd0},
      '{1'b0, CH_MINUS,  1'b1, KIND_MINUS,  8'h00, 16'd0},
      '{1'b0, "i",       1'b1, KIND_TEXT,   "i",   16'd0},
      '{1'b0, "f",       1'b1, KIND_TEXT,   "f",   16'd0},
      '{1'b0, CH_EQUAL,  1'b0, KIND_TEXT,   8'h00, 16'd0},
      '{1'b0, CH_EQUAL,  1'b1, KIND_EQUALS, 8'h00, 16'd0},
      '{1'b0, CH_EQUAL,  1'b0, KIND_TEXT,   8'h00, 16'd0},
      '{1'b0, CH_QUOTE,  1'b1, KIND_ASSIGN, 8'h00, 16'd0},
      '{1'b0, "a",       1'b1, KIND_TEXT,   "a",   16'd0},
      '{1'b0, CH_QUOTE,  1'b1, KIND_STRING, 8'h00, 16'd1},
      '{1'b0, "w",       1'b0, KIND_TEXT,   8'h00, 16'd0},
      '{1'b0, "h",       1'b0, KIND_TEXT,   8'h00, 16'd0},
      '{1'b0, "i",       1'b0, KIND_TEXT,   8'h00, 16'd0},
      '{1'b0, "l",       1'b0, KIND_TEXT,   8'h00, 16'd0},
      '{1'b0, "e",       1'b0, KIND_TEXT,   8'h00, 16'd0},
      '{1'b0, CH_TAB,    1'b0, KIND_TEXT,   8'h00, 16'd0},
      '{1'b0, "4",       1'b0, KIND_TEXT,   8'h00, 16'd0},
      '{1'b0, "2",       1'b0, KIND_TEXT,   8'h00, 16'd0},
      '{1'b0, CH_NL,     1'b0, KIND_TEXT,   8'h00, 16'd0},
      '{1'b0, CH_QUOTE,  1'b0, KIND_TEXT,   8'h00, 16'd0},
      '{1'b1, 8'h5A,     1'b0, KIND_TEXT,   8'h00, 16'd0},
      '{1'b0, CH_EQUAL,  1'b0, KIND_TEXT,   8'h00, 16'd0},
      '{1'b1, 8'hA5,     1'b0, KIND_TEXT,   8'h00, 16'd0},
      '{1'b1, 8'hFF,     1'b1, KIND_END,    8'h00, 16'd0}
   };

   string kw_like [10] = '{"if", "while", "i", "wh", "whil", "whilee", "iff",
                           "whi1e", "ifwhile", "w"};

   source_text_tokenizer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   // token predictor

   function automatic void emit_token(input logic [3:0] kind, input logic [7:0] ch,
                                      input logic [30:0] val, input logic ovf,
                                      input logic [LENGTH_BITS-1:0] len);
      token_type r;
      r.kind = kind;
      r.ch   = ch;
      r.val  = val;
      r.ovf  = ovf;
      r.len  = 16'(len);
      r.last = 1'b0;
      step_tokens.insert(step_tokens.size(), r);
   endfunction

   function automatic void clear_word();
      lex.word_length       = '0;
      lex.all_digits        = 1'b1;
      lex.matches_if        = 1'b1;
      lex.matches_while     = 1'b1;
      lex.value_accumulator = '0;
      lex.overflow_seen     = 1'b0;
   endfunction

   function automatic void grow_length();
      if (lex.word_length != '1) begin
         lex.word_length = lex.word_length + 1'b1;
      end
   endfunction

   // emit the closing kind of the running word, if there is one
   function automatic void close_word();
      if (lex.word_length == '0) begin
         return;
      end
      if (lex.matches_if && lex.word_length == 2) begin
         emit_token(KIND_IF, 8'h00, '0, 1'b0, lex.word_length);
      end else if (lex.matches_while && lex.word_length == 5) begin
         emit_token(KIND_WHILE, 8'h00, '0, 1'b0, lex.word_length);
      end else if (lex.all_digits) begin
         emit_token(KIND_INTEGER, 8'h00, lex.value_accumulator, lex.overflow_seen,
                    lex.word_length);
      end else begin
         emit_token(KIND_IDENT, 8'h00, '0, 1'b0, lex.word_length);
      end
      clear_word();
   endfunction

   // byte outside a string with no pending equal sign
   function automatic void scan_word_byte(input logic [7:0] b);
      logic [3:0]  kind;
      logic [63:0] acc;
      int          pos;
      kind = KIND_TEXT;
      case (b)
         CH_QUOTE: begin
            close_word();
            lex.in_string = 1'b1;
            return;
         end
         CH_EQUAL: begin
            close_word();
            lex.pending_equal_sign = 1'b1;
            return;
         end
         CH_LPAREN: kind = KIND_LPAREN;
         CH_RPAREN: kind = KIND_RPAREN;
         CH_LCURLY: kind = KIND_LCURLY;
         CH_RCURLY: kind = KIND_RCURLY;
         CH_PLUS:   kind = KIND_PLUS;
         CH_MINUS:  kind = KIND_MINUS;
         CH_SPACE, CH_TAB, CH_NL: begin
            close_word();
            return;
         end
         default: ;
      endcase
      if (kind != KIND_TEXT) begin
         close_word();
         emit_token(kind, 8'h00, '0, 1'b0, '0);
         return;
      end
      // keyword tracking by position in the word
      pos = (lex.word_length < 8) ? int'(lex.word_length[2:0]) : 8;
      if (pos >= 2 || KW_IF[8*(1-pos) +: 8] != b) begin
         lex.matches_if = 1'b0;
      end
      if (pos >= 5 || KW_WHILE[8*(4-pos) +: 8] != b) begin
         lex.matches_while = 1'b0;
      end
      // decimal value with saturation
      if (b >= CH_ZERO && b <= CH_NINE) begin
         if (lex.all_digits) begin
            acc = 64'(lex.value_accumulator) * 64'd10 + 64'(b - CH_ZERO);
            if (acc > 64'(VALUE_MAX)) begin
               acc = 64'(VALUE_MAX);
               lex.overflow_seen = 1'b1;
            end
            lex.value_accumulator = acc[30:0];
         end
      end else begin
         lex.all_digits = 1'b0;
      end
      grow_length();
      emit_token(KIND_TEXT, b, '0, 1'b0, '0);
   endfunction

   // drive one word, predict its tokens once it is taken
   task automatic send_word(input logic [7:0] b, input logic eoi,
                            input bit typed = 1'b0, input token_type fixed = '0);
      int gap;
      if (!calm && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 16);
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= eoi;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      words_sent++;

      step_tokens.delete();
      if (eoi) begin
         if (lex.pending_equal_sign) begin
            emit_token(KIND_ASSIGN, 8'h00, '0, 1'b0, '0);
         end
         if (lex.in_string) begin
            emit_token(KIND_UNTERM, 8'h00, '0, 1'b0, lex.word_length);
         end else begin
            close_word();
         end
         emit_token(KIND_END, 8'h00, '0, 1'b0, '0);
         lex = STATE_RESET;
      end else if (lex.in_string) begin
         if (b == CH_QUOTE) begin
            emit_token(KIND_STRING, 8'h00, '0, 1'b0, lex.word_length);
            lex.in_string = 1'b0;
            clear_word();
         end else begin
            grow_length();
            emit_token(KIND_TEXT, b, '0, 1'b0, '0);
         end
      end else if (lex.pending_equal_sign) begin
         lex.pending_equal_sign = 1'b0;
         if (b == CH_EQUAL) begin
            emit_token(KIND_EQUALS, 8'h00, '0, 1'b0, '0);
         end else begin
            emit_token(KIND_ASSIGN, 8'h00, '0, 1'b0, '0);
            scan_word_byte(b);
         end
      end else begin
         scan_word_byte(b);
      end
      if (step_tokens.size() > 0) begin
         step_tokens[step_tokens.size()-1].last = 1'b1;
      end

      if (typed) begin
         pending_tokens.insert(pending_tokens.size(), fixed);
      end else begin
         foreach (step_tokens[k]) pending_tokens.insert(pending_tokens.size(), step_tokens[k]);
      end
      @(negedge clock);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         send_word(s[i], 1'b0);
      end
   endtask

   // one random phrase: mostly well-formed tokens, some noise
   task automatic random_phrase();
      int         pick;
      int         n;
      logic [7:0] c;
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
         send_text(kw_like[$urandom_range(0, 9)]);
      end else if (pick < 24) begin
         n = $urandom_range(1, 8);
         send_word(8'($urandom_range(8'h61, 8'h7A)), 1'b0);
         for (int i = 1; i < n; i++) begin
            case ($urandom_range(0, 2))
               0: c = 8'($urandom_range(8'h61, 8'h7A));
               1: c = 8'($urandom_range(CH_ZERO, CH_NINE));
               default: c = "_";
            endcase
            send_word(c, 1'b0);
         end
      end else if (pick < 38) begin
         n = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 14) : $urandom_range(1, 6);
         for (int i = 0; i < n; i++) begin
            send_word(8'(CH_ZERO + $urandom_range(0, 9)), 1'b0);
         end
      end else if (pick < 50) begin
         send_word(CH_QUOTE, 1'b0);
         n = $urandom_range(0, 8);
         for (int i = 0; i < n; i++) begin
            c = 8'($urandom_range(0, 255));
            send_word((c == CH_QUOTE) ? 8'h27 : c, 1'b0);
         end
         // now and then the string is left open
         if ($urandom_range(0, 9) != 0) begin
            send_word(CH_QUOTE, 1'b0);
         end
      end else if (pick < 62) begin
         case ($urandom_range(0, 5))
            0: send_word(CH_LPAREN, 1'b0);
            1: send_word(CH_RPAREN, 1'b0);
            2: send_word(CH_LCURLY, 1'b0);
            3: send_word(CH_RCURLY, 1'b0);
            4: send_word(CH_PLUS, 1'b0);
            default: send_word(CH_MINUS, 1'b0);
         endcase
      end else if (pick < 70) begin
         n = $urandom_range(1, 3);
         for (int i = 0; i < n; i++) send_word(CH_EQUAL, 1'b0);
      end else if (pick < 80) begin
         n = $urandom_range(1, 3);
         for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 2))
               0: send_word(CH_SPACE, 1'b0);
               1: send_word(CH_TAB, 1'b0);
               default: send_word(CH_NL, 1'b0);
            endcase
         end
      end else if (pick < 85) begin
         send_word(8'($urandom_range(0, 255)), 1'b1);
      end else begin
         n = $urandom_range(1, 3);
         for (int i = 0; i < n; i++) send_word(8'($urandom_range(0, 255)), 1'b0);
      end
   endtask

   // result side back-pressure in bursts
   always @(negedge clock) begin
      if (calm || reset) begin
         rsp_tready <= 1'b1;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 15);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic report_miss(input string what, input token_type want, input token_type seen);
      mismatches++;
      if (mismatches <= 10) begin
         $display("%0t %s: kind %0d/%0d char %h/%h value %0d/%0d ovf %b/%b len %0d/%0d last %b/%b",
                  $time, what, want.kind, seen.kind, want.ch, seen.ch, want.val, seen.val,
                  want.ovf, seen.ovf, want.len, seen.len, want.last, seen.last);
      end
   endtask

   // compare each taken result word with the oldest expected token
   always @(posedge clock) begin : rsp_check
      token_type seen;
      token_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen = '{rsp_tuser, rsp_tdata[7:0], rsp_tdata[38:8], rsp_tdata[39],
                  rsp_tdata[55:40], rsp_tlast};
         if (pending_tokens.size() == 0) begin
            report_miss("unexpected word (want/got)", '0, seen);
         end else begin
            want = pending_tokens.pop_front();
            if (seen !== want) begin
               report_miss("mismatch (want/got)", want, seen);
            end
         end
      end
   end

   // watchdog on cycles where nothing moves
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin : stimulus
      stim_type  row;
      token_type fixed;
      logic [7:0] c;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed rows
      for (int i = 0; i < NDIRECTED; i++) begin
         row = directed_rows[i];
         fixed = '{row.kind, row.ch, 31'd0, 1'b0, row.len, 1'b1};
         send_word(row.b, row.eoi, row.typed, fixed);
      end

      // random phrases, quiet handshakes toward the end
      while (words_sent < NDIRECTED + RANDOM_WORDS) begin
         if (words_sent >= NDIRECTED + CALM_AFTER) calm = 1'b1;
         random_phrase();
         if ($urandom_range(0, 1) == 0) send_word(CH_SPACE, 1'b0);
      end
      calm = 1'b1;
      send_word(8'h00, 1'b1);

      // a longer string of random bytes and an overflowing integer
      send_word(CH_QUOTE, 1'b0);
      for (int i = 0; i < LONG_RUN; i++) begin
         c = 8'($urandom_range(0, 255));
         send_word((c == CH_QUOTE) ? 8'h00 : c, 1'b0);
      end
      send_word(CH_QUOTE, 1'b0);
      for (int i = 0; i < LONG_RUN; i++) send_word("9", 1'b0);
      send_word(CH_SPACE, 1'b0);
      send_word(8'h00, 1'b1);

      req_tvalid <= 1'b0;
      while (pending_tokens.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
